>>> sv/stwv_pkg.sv
// ----------------------------------------------------------------------------
// stwv_pkg
// types and codes shared by the slot table modules
// ----------------------------------------------------------------------------
package stwv_pkg;

  // operation codes carried in the func field
  localparam logic [2:0] FUNC_PUSH_BACK = 3'd0;
  localparam logic [2:0] FUNC_INSERT_AT = 3'd1;
  localparam logic [2:0] FUNC_READ      = 3'd2;
  localparam logic [2:0] FUNC_ALLOCATE  = 3'd3;
  localparam logic [2:0] FUNC_DELETE    = 3'd4;
  localparam logic [2:0] FUNC_FIND      = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_MASK    = 1'd1;

  // configuration reset values
  localparam logic [8:0]  CAPACITY_RESET = 9'd256;
  localparam logic [31:0] MASK_RESET     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot_index;
    logic [31:0] element_data;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [8:0]  result_index;
    logic [31:0] read_data;
    logic [8:0]  valid_count;
  } out_word_t;

endpackage

>>> sv/stwv_mem.sv
// ----------------------------------------------------------------------------
// stwv_mem
// slot store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module stwv_mem #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/stwv_ctrl.sv
// ----------------------------------------------------------------------------
// stwv_ctrl
// operation sequencer: clearing pass, read-modify-write and slot scans
// ----------------------------------------------------------------------------
module stwv_ctrl #(
  parameter int unsigned SLOTS         = 256,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  stwv_pkg::in_word_t            in_word,
  input  logic                          cfg_valid,
  input  logic [stwv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          res_valid,
  input  logic                          res_take,
  output stwv_pkg::out_word_t           res_word,
  output logic                          mem_rd_en,
  output logic [$clog2(SLOTS)-1:0]      mem_rd_addr,
  input  logic [ELEMENT_WIDTH:0]        mem_rd_data,
  output logic                          mem_wr_en,
  output logic [$clog2(SLOTS)-1:0]      mem_wr_addr,
  output logic [ELEMENT_WIDTH:0]        mem_wr_data
);
  import stwv_pkg::*;

  localparam int unsigned AW  = $clog2(SLOTS);
  localparam int unsigned BPW = $clog2(SLOTS + 1);
  localparam int unsigned CW  = (BPW > 9) ? BPW : 9;
  localparam int unsigned EW  = ELEMENT_WIDTH;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t         state;
  logic [AW-1:0]  clr_addr;
  logic [BPW-1:0] back_ptr;
  logic [BPW-1:0] valid_total;
  logic [8:0]     cap_reg;
  logic [31:0]    mask_reg;
  logic [2:0]     op_func;
  logic [AW-1:0]  op_addr;
  logic [EW-1:0]  op_data;
  logic [BPW-1:0] scan_addr;
  logic           scan_pend;
  logic [AW-1:0]  pend_addr;
  logic           res_ok;
  logic [BPW-1:0] res_idx;
  logic [31:0]    res_rd;

  logic [CW-1:0]  cap_ext;
  logic [BPW-1:0] eff_cap;
  logic [CW-1:0]  cap_w;
  logic [CW-1:0]  idx_w;
  logic [CW-1:0]  back_w;
  logic [CW-1:0]  total_w;
  logic           accept;
  logic           go_exec;
  logic           go_scan;
  logic [AW-1:0]  acc_addr;
  logic [EW-1:0]  in_data_cut;
  logic [EW-1:0]  rd_elem;
  logic           rd_vld;
  logic [63:0]    rd_elem64;
  logic [EW-1:0]  mask_w;
  logic           scan_issue;
  logic           scan_hit;

  // effective capacity, never above the built slot count
  assign cap_ext = CW'(cap_reg);
  assign eff_cap = (cap_ext > CW'(SLOTS)) ? BPW'(SLOTS) : BPW'(cap_ext);
  assign cap_w   = CW'(eff_cap);
  assign idx_w   = CW'(in_word.slot_index);
  assign back_w  = CW'(back_ptr);
  assign total_w = CW'(valid_total);

  assign accept      = in_valid && (state == S_IDLE);
  assign in_stall    = (state != S_IDLE);
  assign in_data_cut = EW'(in_word.element_data);

  assign rd_elem   = mem_rd_data[EW-1:0];
  assign rd_vld    = mem_rd_data[EW];
  assign rd_elem64 = 64'(rd_elem);
  assign mask_w    = EW'(mask_reg);

  // entry checks for the incoming word
  always_comb begin
    go_exec  = 1'b0;
    go_scan  = 1'b0;
    acc_addr = AW'(in_word.slot_index);
    case (in_word.func)
      FUNC_PUSH_BACK: begin
        go_exec  = (back_w < cap_w);
        acc_addr = AW'(back_ptr);
      end
      FUNC_INSERT_AT: go_exec = (idx_w < cap_w);
      FUNC_READ:      go_exec = (idx_w < back_w);
      FUNC_ALLOCATE: begin
        acc_addr = AW'(back_ptr);
        if (total_w < cap_w) begin
          go_exec = (back_w < cap_w);
          go_scan = !(back_w < cap_w);
        end
      end
      FUNC_DELETE:    go_exec = (idx_w < cap_w);
      FUNC_FIND:      go_scan = 1'b1;
      default:        go_exec = 1'b0;
    endcase
  end

  // scan compare on the word returned for pend_addr
  always_comb begin
    if (op_func == FUNC_ALLOCATE) begin
      scan_hit = scan_pend && !rd_vld;
    end else begin
      scan_hit = scan_pend && rd_vld && (((rd_elem ^ op_data) & mask_w) == '0);
    end
  end

  assign scan_issue = (scan_addr < eff_cap) && !scan_hit;

  assign mem_rd_en   = (accept && go_exec) || ((state == S_SCAN) && scan_issue);
  assign mem_rd_addr = (state == S_SCAN) ? AW'(scan_addr) : acc_addr;

  // write port
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = op_addr;
    mem_wr_data = {1'b1, op_data};
    case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      S_EXEC: begin
        case (op_func)
          FUNC_PUSH_BACK, FUNC_INSERT_AT: mem_wr_en = 1'b1;
          FUNC_ALLOCATE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {1'b1, rd_elem};
          end
          FUNC_DELETE: begin
            mem_wr_en   = rd_vld;
            mem_wr_data = {1'b0, rd_elem};
          end
          default: mem_wr_en = 1'b0;
        endcase
      end
      S_SCAN: begin
        mem_wr_en   = scan_hit && (op_func == FUNC_ALLOCATE);
        mem_wr_addr = pend_addr;
        mem_wr_data = {1'b1, rd_elem};
      end
      default: mem_wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      back_ptr    <= '0;
      valid_total <= '0;
      cap_reg     <= CAPACITY_RESET;
      mask_reg    <= MASK_RESET;
      scan_pend   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CAPACITY_IN_USE: cap_reg  <= cfg_data[8:0];
          CFG_COMPARE_MASK:    mask_reg <= cfg_data;
          default:             cap_reg  <= cap_reg;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_func   <= in_word.func;
            op_addr   <= acc_addr;
            op_data   <= in_data_cut;
            res_ok    <= 1'b0;
            res_idx   <= '0;
            res_rd    <= '0;
            scan_addr <= '0;
            scan_pend <= 1'b0;
            if (go_exec) begin
              state <= S_EXEC;
            end else if (go_scan) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (op_func)
            FUNC_PUSH_BACK, FUNC_ALLOCATE: begin
              if (!rd_vld) begin
                valid_total <= valid_total + BPW'(1);
              end
              res_idx  <= back_ptr;
              back_ptr <= back_ptr + BPW'(1);
              res_ok   <= 1'b1;
            end
            FUNC_INSERT_AT: begin
              if (!rd_vld) begin
                valid_total <= valid_total + BPW'(1);
              end
              if (BPW'(op_addr) >= back_ptr) begin
                back_ptr <= BPW'(op_addr) + BPW'(1);
              end
              res_idx <= BPW'(op_addr);
              res_ok  <= 1'b1;
            end
            FUNC_READ: begin
              if (rd_vld) begin
                res_rd  <= rd_elem64[31:0];
                res_idx <= BPW'(op_addr);
                res_ok  <= 1'b1;
              end
            end
            FUNC_DELETE: begin
              if (rd_vld) begin
                valid_total <= valid_total - BPW'(1);
                res_idx     <= BPW'(op_addr);
                res_ok      <= 1'b1;
              end
            end
            default: res_ok <= 1'b0;
          endcase
        end
        S_SCAN: begin
          if (scan_hit) begin
            state   <= S_DONE;
            res_ok  <= 1'b1;
            res_idx <= BPW'(pend_addr);
            if (op_func == FUNC_ALLOCATE) begin
              valid_total <= valid_total + BPW'(1);
            end
          end else begin
            // find keeps one past the last valid slot seen
            if (scan_pend && rd_vld && (op_func == FUNC_FIND)) begin
              res_idx <= BPW'(pend_addr) + BPW'(1);
            end
            if (scan_issue) begin
              pend_addr <= AW'(scan_addr);
              scan_addr <= scan_addr + BPW'(1);
              scan_pend <= 1'b1;
            end else begin
              scan_pend <= 1'b0;
            end
            if (!scan_pend && !scan_issue) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_valid             = (state == S_DONE);
  assign res_word.ok           = res_ok;
  assign res_word.result_index = 9'(res_idx);
  assign res_word.read_data    = res_rd;
  assign res_word.valid_count  = 9'(valid_total);

endmodule

>>> sv/slot_table_with_valid_bits.sv
// ----------------------------------------------------------------------------
// slot_table_with_valid_bits
// table of element slots with valid bits, back pointer and valid count
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall / in_word) carries one operation word:
//   push_back, insert_at, read, allocate, delete or find. every accepted word
//   gives exactly one result word on the output channel, in order.
//   config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   capacity_in_use or compare_mask; cfg_ready is always high, write only
//   while the table is idle.
// operation flow
//   one word at a time. direct operations go through memory read,
//   modify/write and result; allocate-by-scan and find read one slot a
//   cycle through the single read port of the slot memory. a new word
//   is taken the cycle after the result moves into the output register.
// reset
//   rst is synchronous. afterwards a clearing pass writes every slot to
//   zero with in_stall high; config writes are taken anyway.
// stall
//   the output register holds its word while out_stall is high; the next
//   operation may still be accepted and runs up to its result meanwhile.
// ----------------------------------------------------------------------------
module slot_table_with_valid_bits #(
  parameter int unsigned SLOTS         = 256,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  stwv_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output stwv_pkg::out_word_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stwv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);
  import stwv_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);

  // slot memory ports, entry is {valid, element}
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [ELEMENT_WIDTH:0] mem_rd_data;
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [ELEMENT_WIDTH:0] mem_wr_data;

  // finished result from the sequencer
  logic      res_valid;
  logic      res_take;
  out_word_t res_word;

  assign cfg_ready = 1'b1;

  stwv_mem #(
    .SLOTS (SLOTS),
    .WIDTH (ELEMENT_WIDTH + 1)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  stwv_ctrl #(
    .SLOTS         (SLOTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_word    (res_word),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // output register: loads when empty or when its word leaves this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res_word;
    end
  end

endmodule

>>> sv/stwv_chk.sv
// ----------------------------------------------------------------------------
// stwv_chk
// port-level checks for the slot table, bound to the top level
// ----------------------------------------------------------------------------
module stwv_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input stwv_pkg::out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // reset starts the clearing pass with no result pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("table not busy or result shown after reset");

  // one word at a time: the cycle after an accept takes nothing
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted back to back");

  // failed operations return no element
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.ok |-> out_word.read_data == 32'd0)
    else $error("read data on a failed operation");

endmodule

bind slot_table_with_valid_bits stwv_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for slot_table_with_valid_bits
// ----------------------------------------------------------------------------
// every operation word taken by the table is run through a model of the slot
// table kept here. the model's answer is queued, and each result word is
// compared field by field against the oldest queued answer. a short directed
// part walks the empty table, each operation and the capacity corner cases.
// random traffic then runs under several capacity and compare-mask settings
// and several idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stwv_pkg::*;

  localparam int          SLOTS       = 256;
  localparam logic [8:0]  SLOT_COUNT  = 9'd256;
  localparam int          CYCLE_LIMIT = 2_000_000;
  // long enough for a full-table scan to come out
  localparam int          TAIL_CYCLES = SLOTS + 16;

  // codes the table has no operation for
  localparam logic [2:0]  FUNC_UNUSED_6 = 3'd6;
  localparam logic [2:0]  FUNC_UNUSED_7 = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_word_t               in_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  // model of the table state and its registers
  logic                   slot_valid [SLOTS] = '{default: 1'b0};
  logic [31:0]            slot_data  [SLOTS] = '{default: 32'd0};
  logic [8:0]             back_ptr     = 9'd0;
  logic [8:0]             live_count   = 9'd0;
  logic [8:0]             cap_setting  = CAPACITY_RESET;
  logic [31:0]            mask_setting = MASK_RESET;

  // answers waiting for their result word
  out_word_t              pending_results [$];

  int                     send_idle_pct   = 0;
  int                     stall_pct       = 0;
  int                     mismatch_count  = 0;
  int                     words_sent      = 0;
  int                     results_checked = 0;
  int                     find_hits       = 0;
  int                     scan_allocs     = 0;
  int                     register_writes = 0;
  int                     cycle_count     = 0;

  slot_table_with_valid_bits dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // receiver side: random stall, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // model of one table operation; updates the model state and gives the
  // result word the table should return
  // ---------------------------------------------------------------------------
  function automatic out_word_t predict_table_op(input in_word_t w);
    out_word_t  r;
    logic [8:0] cap;
    logic [8:0] idx;
    logic       found;
    r     = '0;
    // register values above the table size mean the whole table
    cap   = (cap_setting > SLOT_COUNT) ? SLOT_COUNT : cap_setting;
    idx   = {1'b0, w.slot_index};
    found = 1'b0;
    case (w.func)
      FUNC_PUSH_BACK: begin
        if (back_ptr < cap) begin
          slot_data[back_ptr] = w.element_data;
          if (!slot_valid[back_ptr]) begin
            slot_valid[back_ptr] = 1'b1;
            live_count++;
          end
          r.result_index = back_ptr;
          r.ok           = 1'b1;
          back_ptr++;
        end
      end
      FUNC_INSERT_AT: begin
        if (idx < cap) begin
          slot_data[idx] = w.element_data;
          if (!slot_valid[idx]) begin
            slot_valid[idx] = 1'b1;
            live_count++;
          end
          if (idx >= back_ptr) back_ptr = idx + 9'd1;
          r.result_index = idx;
          r.ok           = 1'b1;
        end
      end
      FUNC_READ: begin
        // capacity does not limit reads, only the back pointer does
        if (idx < back_ptr && slot_valid[idx]) begin
          r.read_data    = slot_data[idx];
          r.result_index = idx;
          r.ok           = 1'b1;
        end
      end
      FUNC_ALLOCATE: begin
        if (live_count < cap) begin
          if (back_ptr < cap) begin
            if (!slot_valid[back_ptr]) begin
              slot_valid[back_ptr] = 1'b1;
              live_count++;
            end
            r.result_index = back_ptr;
            r.ok           = 1'b1;
            back_ptr++;
          end else begin
            // back slot used up: first free slot below capacity
            for (int i = 0; i < cap; i++) begin
              if (!found && !slot_valid[i]) begin
                found          = 1'b1;
                slot_valid[i]  = 1'b1;
                live_count++;
                r.result_index = 9'(i);
                r.ok           = 1'b1;
              end
            end
            if (found) scan_allocs++;
          end
        end
      end
      FUNC_DELETE: begin
        if (idx < cap && slot_valid[idx]) begin
          slot_valid[idx] = 1'b0;
          live_count--;
          r.result_index  = idx;
          r.ok            = 1'b1;
        end
      end
      FUNC_FIND: begin
        // a miss leaves one past the last valid slot seen
        for (int i = 0; i < cap; i++) begin
          if (!found && slot_valid[i]) begin
            r.result_index = 9'(i + 1);
            if (((slot_data[i] ^ w.element_data) & mask_setting) == 32'd0) begin
              found          = 1'b1;
              r.result_index = 9'(i);
              r.ok           = 1'b1;
            end
          end
        end
        if (found) find_hits++;
      end
      default: ;
    endcase
    r.valid_count = live_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random operation word, biased toward slots the table is actually using
  // ---------------------------------------------------------------------------
  function automatic in_word_t random_op();
    in_word_t    w;
    int unsigned pick;
    int unsigned span;
    logic [8:0]  cap;
    cap  = (cap_setting > SLOT_COUNT) ? SLOT_COUNT : cap_setting;
    span = (back_ptr > cap) ? back_ptr : cap;
    pick = $urandom_range(99);
    // a few tiny values so that equal elements turn up
    w.element_data = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
    if (span == 0 || $urandom_range(3) == 0) w.slot_index = 8'($urandom_range(255));
    else w.slot_index = 8'($urandom_range(span - 1));
    if (pick < 16) w.func = FUNC_PUSH_BACK;
    else if (pick < 34) w.func = FUNC_INSERT_AT;
    else if (pick < 54) w.func = FUNC_READ;
    else if (pick < 68) w.func = FUNC_ALLOCATE;
    else if (pick < 82) w.func = FUNC_DELETE;
    else if (pick < 97) begin
      w.func = FUNC_FIND;
      // mostly keys equal to a stored element on the compared bits
      if ($urandom_range(3) != 0)
        w.element_data = slot_data[w.slot_index] ^ ($urandom & ~mask_setting);
    end else w.func = pick[0] ? FUNC_UNUSED_6 : FUNC_UNUSED_7;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: called at a falling edge, returns at the falling edge after the
  // word was taken with in_valid still high, so back-to-back words never drop it
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_table_op(w));
    words_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every queued answer has been matched
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // writes both registers back to back while the table is idle
  task automatic write_registers(input logic [8:0] capacity, input logic [31:0] mask);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CAPACITY_IN_USE;
    cfg_data  <= {23'd0, capacity};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_setting = capacity;
    @(negedge clk);
    cfg_index <= CFG_COMPARE_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mask_setting = mask;
    @(negedge clk);
    cfg_valid <= 1'b0;
    register_writes += 2;
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_word(random_op());
      // now and then let the table answer everything before going on
      if (n % 60 == 59) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h expected %h", results_checked,
                                name, got, want));
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", out_word));
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 32'(out_word.ok), 32'(want.ok));
        check_field("result_index", 32'(out_word.result_index), 32'(want.result_index));
        check_field("read_data", out_word.read_data, want.read_data);
        check_field("valid_count", 32'(out_word.valid_count), 32'(want.valid_count));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // fresh table: nothing valid, nothing found, unused codes do nothing
  task automatic test_empty_table();
    send_word(in_word_t'{FUNC_READ,     8'd0,   32'd0});
    send_word(in_word_t'{FUNC_FIND,     8'd0,   32'd0});
    send_word(in_word_t'{FUNC_DELETE,   8'd0,   32'd0});
    send_word(in_word_t'{FUNC_UNUSED_6, 8'd255, 32'hFFFF_FFFF});
    send_word(in_word_t'{FUNC_UNUSED_7, 8'd128, 32'h8000_0001});
  endtask

  // each operation at least once at full capacity, keeping the back pointer low
  task automatic test_basic_operations();
    send_word(in_word_t'{FUNC_PUSH_BACK, 8'd0,   32'h0000_0000});
    send_word(in_word_t'{FUNC_PUSH_BACK, 8'd0,   32'hFFFF_FFFF});
    send_word(in_word_t'{FUNC_ALLOCATE,  8'd0,   32'd0});
    // insert past the back pointer drags it along
    send_word(in_word_t'{FUNC_INSERT_AT, 8'd5,   32'hA5A5_5A5A});
    send_word(in_word_t'{FUNC_READ,      8'd1,   32'd0});
    send_word(in_word_t'{FUNC_READ,      8'd5,   32'd0});
    // hole below the back pointer, then far past it
    send_word(in_word_t'{FUNC_READ,      8'd3,   32'd0});
    send_word(in_word_t'{FUNC_READ,      8'd255, 32'd0});
    send_word(in_word_t'{FUNC_FIND,      8'd0,   32'hFFFF_FFFF});
    // miss reports one past the last valid slot
    send_word(in_word_t'{FUNC_FIND,      8'd0,   32'h1234_5678});
    send_word(in_word_t'{FUNC_DELETE,    8'd5,   32'd0});
    send_word(in_word_t'{FUNC_DELETE,    8'd5,   32'd0});
    send_word(in_word_t'{FUNC_DELETE,    8'd255, 32'd0});
    // overwrite of a valid slot leaves the count alone
    send_word(in_word_t'{FUNC_INSERT_AT, 8'd1,   32'h0F0F_0F0F});
  endtask

  // capacity below the back pointer and equal to the live count, masked find
  task automatic test_capacity_limits();
    write_registers(9'd3, 32'h0000_00FF);
    send_word(in_word_t'{FUNC_PUSH_BACK, 8'd0,   32'h1111_1111});
    send_word(in_word_t'{FUNC_INSERT_AT, 8'd255, 32'h2222_2222});
    send_word(in_word_t'{FUNC_ALLOCATE,  8'd0,   32'd0});
    send_word(in_word_t'{FUNC_DELETE,    8'd2,   32'd0});
    // back pointer past capacity: allocation has to scan for the hole
    send_word(in_word_t'{FUNC_ALLOCATE,  8'd0,   32'd0});
    send_word(in_word_t'{FUNC_FIND,      8'd0,   32'hFFFF_FF0F});
  endtask

  // ---------------------------------------------------------------------------
  // random tests; small capacities first so the back pointer path stays
  // reachable before the wide settings spread it across the table
  // ---------------------------------------------------------------------------
  task automatic test_random_sender_idle();
    send_idle_pct = 88;
    stall_pct     = 0;
    write_registers(9'd8, $urandom);
    run_random(220);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 24;
    stall_pct     = 24;
    write_registers(9'd17, 32'h0000_0000);
    run_random(220);
  endtask

  // no usable slot: only reads can succeed
  task automatic test_zero_capacity();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_registers(9'd0, 32'h0000_FFFF);
    run_random(40);
  endtask

  // largest register value, taken as the full table
  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct     = 88;
    write_registers(9'd511, 32'hFFFF_0000);
    run_random(250);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_registers(SLOT_COUNT, 32'hFFFF_FFFF);
    run_random(250);
  endtask

  // slots above the new capacity stay live and readable
  task automatic test_lowered_capacity();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_registers(9'd40, $urandom);
    run_random(50);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_basic_operations();
    test_capacity_limits();
    test_random_sender_idle();
    test_random_both_idle();
    test_zero_capacity();
    test_random_receiver_stall();
    test_random_no_idle();
    test_lowered_capacity();

    // drain, then give a stray word time to show up
    wait_drained();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d operation words, %0d result words checked, %0d register writes",
             words_sent, results_checked, register_writes);
    $display("%0d find hits, %0d scan allocations, %0d mismatches in %0d cycles",
             find_hits, scan_allocs, mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/stwv_pkg.sv
sv/stwv_mem.sv
sv/stwv_ctrl.sv
sv/slot_table_with_valid_bits.sv
sv/stwv_chk.sv
tb/tb.sv
